// File: design/vgfm_pkg.sv
// Package with shared types, constants and helper functions of the voxel mesher.
`timescale 1ns / 1ps
package vgfm_pkg;
   localparam int SideLen = 8;
   localparam int CoordW = 3;
   localparam int AddrW = 9;
   localparam int ColorW = 32;
   localparam int ExtW = 4;
   localparam int MaxOut = 32;
   localparam int CountW = 6;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_MESH = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [CoordW-1:0]     pos_x;
      logic [CoordW-1:0]     pos_y;
      logic [CoordW-1:0]     pos_z;
      logic                  active;
      logic [ColorW-1:0]     voxel_color;
      logic [2:0]            face_side;
      logic [CoordW-1:0]     slice_index;
   } req_word_type;

   typedef struct packed {
      logic [2:0]            side;
      logic [CoordW-1:0]     slice;
      logic [CoordW-1:0]     u_start;
      logic [CoordW-1:0]     v_start;
      logic [ExtW-1:0]       width;
      logic [ExtW-1:0]       height;
      logic [ColorW-1:0]     color;
      logic                  none_found;
      logic                  last;
   } rsp_word_type;

   typedef struct packed {
      logic                  wr_en;
      logic [AddrW-1:0]      wr_addr;
      logic                  wr_solid;
      logic [ColorW-1:0]     wr_color;
      logic                  rd_en;
      logic [AddrW-1:0]      rd_addr;
   } mem_ctl_type;

   function automatic logic [1:0] side_axis(input logic [2:0] side);
      logic [1:0] a;
      a = 2'd0;
      unique case (side)
         3'd0, 3'd1: a = 2'd1;
         3'd2, 3'd3: a = 2'd2;
         default:    a = 2'd0;
      endcase
      return a;
   endfunction

   function automatic logic side_pos(input logic [2:0] side);
      return (side == 3'd0) || (side == 3'd3) || (side == 3'd5);
   endfunction

   function automatic logic [AddrW-1:0] cell_addr(input logic [1:0] axis,
         input logic [CoordW-1:0] s, input logic [CoordW-1:0] u,
         input logic [CoordW-1:0] v);
      logic [CoordW-1:0] x, y, z;
      x = s; y = u; z = v;
      unique case (axis)
         2'd0:    begin x = s; y = u; z = v; end
         2'd1:    begin y = s; z = u; x = v; end
         default: begin z = s; x = u; y = v; end
      endcase
      return {z, y, x};
   endfunction
endpackage

// File: design/vgfm_if.sv
// Valid-ready channel interface carrying one word of a generic payload type.
`timescale 1ns / 1ps
interface vgfm_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/voxel_greedy_face_mesher_core.sv
// Top level of the greedy voxel face mesher.
//  channel | dir | payload
//  req     | in  | req_word_type: voxel write or slice mesh request
//  rsp     | out | rsp_word_type: one merged rectangle per word
// After reset a clearing pass over all 512 cells runs before the first word is taken.
// A write is done when its word is taken. A seed cell already covered is skipped;
// a covered growth cell goes to NBR_CHK; others pass CELL_RD, and solid ones NBR_RD.
// A slice with no faces probes all 64 seed cells; rectangle growth adds more probes.
// Each rectangle is held in pend_ff so that the final one can carry last.
// A stalled rsp side holds the sequencer and keeps req_ready low.
`timescale 1ns / 1ps
module voxel_greedy_face_mesher_core (
   input logic clock,
   input logic reset,
   vgfm_if.sink req,
   vgfm_if.source rsp
);
   import vgfm_pkg::*;
   mem_ctl_type ctl;
   logic rd_solid;
   logic [ColorW-1:0] rd_color;

   vgfm_voxel_mem u_mem (.clock(clock), .ctl(ctl), .rd_solid(rd_solid), .rd_color(rd_color));

   vgfm_sequencer u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_word(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_word(rsp.data),
      .ctl(ctl), .rd_solid(rd_solid), .rd_color(rd_color)
   );
endmodule

// File: design/vgfm_voxel_mem.sv
// Voxel memory holding the active bit and color of every cell, with a registered read port.
`timescale 1ns / 1ps
module vgfm_voxel_mem (
   input  logic                    clock,
   input  vgfm_pkg::mem_ctl_type   ctl,
   output logic                    rd_solid,
   output logic [vgfm_pkg::ColorW-1:0] rd_color
);
   import vgfm_pkg::*;
   logic [ColorW:0] mem_ff [0:(1<<AddrW)-1];
   logic [ColorW:0] rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= {ctl.wr_solid, ctl.wr_color};
      end
      if (ctl.rd_en) begin
         rd_ff <= mem_ff[ctl.rd_addr];
      end
   end
   assign rd_solid = rd_ff[ColorW];
   assign rd_color = rd_ff[ColorW-1:0];
endmodule

// File: design/vgfm_sequencer.sv
// Sequencer that clears the grid, performs writes and greedily meshes one slice.
`timescale 1ns / 1ps
module vgfm_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  vgfm_pkg::req_word_type   req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vgfm_pkg::rsp_word_type   rsp_word,
   output vgfm_pkg::mem_ctl_type    ctl,
   input  logic                     rd_solid,
   input  logic [vgfm_pkg::ColorW-1:0] rd_color
);
   import vgfm_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_CELL_RD, ST_NBR_RD, ST_NBR_CHK,
      ST_EMIT, ST_EMPTY, ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {PH_SEED, PH_GROW_U, PH_GROW_V} phase_type;

   state_type state_ff;
   phase_type phase_ff;
   logic [AddrW-1:0] clr_ff;
   logic [2:0] side_ff;
   logic [CoordW-1:0] slice_ff;
   logic [1:0] axis_ff;
   logic nbr_ok_ff;
   logic [CoordW-1:0] nbr_slice_ff;
   logic [CoordW:0] u_ff, v_ff;
   logic [CoordW:0] pu_ff, pv_ff;
   logic [CoordW:0] i_ff;
   logic [ExtW-1:0] w_ff, h_ff;
   logic [ColorW-1:0] col_ff, cand_col_ff;
   logic [SideLen*SideLen-1:0] cov_ff;
   logic [CountW-1:0] cnt_ff;
   logic rsp_valid_ff;
   rsp_word_type rsp_ff;
   rsp_word_type pend_ff;

   logic [CoordW-1:0] pu, pv;
   logic covered, face_ok;
   logic [CoordW:0] next_u;
   logic slot_free, rsp_load;
   rsp_word_type fin_word;

   assign pu = pu_ff[CoordW-1:0];
   assign pv = pv_ff[CoordW-1:0];
   assign covered = cov_ff[{pv, pu}];

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = slot_free && ((state_ff == ST_EMIT && cnt_ff != '0)
         || state_ff == ST_FLUSH || state_ff == ST_EMPTY);

   always_comb begin
      fin_word = pend_ff;
      fin_word.last = 1'b1;
   end

   always_comb begin
      ctl = '0;
      if (state_ff == ST_CLEAR) begin
         ctl.wr_en = 1'b1;
         ctl.wr_addr = clr_ff;
      end else if (state_ff == ST_IDLE && req_valid && req_ready
            && req_word.kind == KIND_WRITE) begin
         ctl.wr_en = 1'b1;
         ctl.wr_addr = {req_word.pos_z, req_word.pos_y, req_word.pos_x};
         ctl.wr_solid = req_word.active;
         ctl.wr_color = req_word.voxel_color;
      end
      // The neighbor word is held in the read register until it is checked.
      ctl.rd_en = (state_ff != ST_NBR_RD);
      ctl.rd_addr = (state_ff == ST_CELL_RD) ? cell_addr(axis_ff, nbr_slice_ff, pu, pv)
                                             : cell_addr(axis_ff, slice_ff, pu, pv);
   end

   // A face exists if the probe cell is solid and the neighbor read is not solid or absent.
   assign face_ok = nbr_ok_ff ? !rd_solid : 1'b1;

   always_comb begin
      next_u = u_ff + {1'b0, w_ff[CoordW-1:0]};
      if (w_ff == ExtW'(SideLen)) next_u = (CoordW+1)'(SideLen);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PH_SEED;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid && req_ready && req_word.kind == KIND_MESH) begin
                  side_ff <= req_word.face_side;
                  slice_ff <= req_word.slice_index;
                  axis_ff <= side_axis(req_word.face_side);
                  if (side_pos(req_word.face_side)) begin
                     nbr_ok_ff <= req_word.slice_index != CoordW'(SideLen-1);
                     nbr_slice_ff <= req_word.slice_index + 1'b1;
                  end else begin
                     nbr_ok_ff <= req_word.slice_index != '0;
                     nbr_slice_ff <= req_word.slice_index - 1'b1;
                  end
                  cov_ff <= '0;
                  cnt_ff <= '0;
                  u_ff <= '0;
                  v_ff <= '0;
                  pu_ff <= '0;
                  pv_ff <= '0;
                  phase_ff <= PH_SEED;
                  if (req_word.face_side > 3'd5) state_ff <= ST_EMPTY;
                  else state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // Address of the probe cell is on the read port this cycle.
               if (phase_ff == PH_SEED && covered) begin
                  if (u_ff == (CoordW+1)'(SideLen-1)) begin
                     if (v_ff == (CoordW+1)'(SideLen-1)) begin
                        state_ff <= (cnt_ff == '0) ? ST_EMPTY : ST_FLUSH;
                     end else begin
                        v_ff <= v_ff + 1'b1; u_ff <= '0;
                        pv_ff <= v_ff + 1'b1; pu_ff <= '0;
                     end
                  end else begin
                     u_ff <= u_ff + 1'b1; pu_ff <= u_ff + 1'b1;
                  end
               end else if (phase_ff != PH_SEED && covered) begin
                  state_ff <= ST_NBR_CHK;
                  cand_col_ff <= '0;
                  nbr_ok_ff <= nbr_ok_ff;
               end else begin
                  state_ff <= ST_CELL_RD;
               end
            end
            ST_CELL_RD: begin
               cand_col_ff <= rd_color;
               state_ff <= rd_solid ? ST_NBR_RD : ST_NBR_CHK;
               i_ff <= {CoordW+1{1'b0}} | {3'b0, rd_solid};
            end
            ST_NBR_RD: begin
               state_ff <= ST_NBR_CHK;
            end
            ST_NBR_CHK: begin
               // i_ff[0] holds cell solidity; covered cells in grow phases fail on covered.
               if (phase_ff == PH_SEED) begin
                  if (i_ff[0] && face_ok) begin
                     col_ff <= cand_col_ff;
                     w_ff <= ExtW'(1);
                     h_ff <= ExtW'(1);
                     if (u_ff == (CoordW+1)'(SideLen-1)) begin
                        phase_ff <= PH_GROW_V;
                        pu_ff <= u_ff; pv_ff <= v_ff + 1'b1;
                        state_ff <= (v_ff == (CoordW+1)'(SideLen-1)) ? ST_EMIT : ST_SCAN;
                     end else begin
                        phase_ff <= PH_GROW_U;
                        pu_ff <= u_ff + 1'b1;
                        state_ff <= ST_SCAN;
                     end
                  end else begin
                     if (u_ff == (CoordW+1)'(SideLen-1)) begin
                        if (v_ff == (CoordW+1)'(SideLen-1)) begin
                           state_ff <= (cnt_ff == '0) ? ST_EMPTY : ST_FLUSH;
                        end else begin
                           state_ff <= ST_SCAN;
                           v_ff <= v_ff + 1'b1; u_ff <= '0;
                           pv_ff <= v_ff + 1'b1; pu_ff <= '0;
                        end
                     end else begin
                        state_ff <= ST_SCAN;
                        u_ff <= u_ff + 1'b1; pu_ff <= u_ff + 1'b1;
                     end
                  end
               end else if (phase_ff == PH_GROW_U) begin
                  if (i_ff[0] && face_ok && cand_col_ff == col_ff && !covered) begin
                     w_ff <= w_ff + 1'b1;
                     if (pu_ff == (CoordW+1)'(SideLen-1)) begin
                        phase_ff <= PH_GROW_V;
                        pu_ff <= u_ff; pv_ff <= v_ff + 1'b1;
                        state_ff <= (v_ff == (CoordW+1)'(SideLen-1)) ? ST_EMIT : ST_SCAN;
                     end else begin
                        pu_ff <= pu_ff + 1'b1;
                        state_ff <= ST_SCAN;
                     end
                  end else begin
                     phase_ff <= PH_GROW_V;
                     pu_ff <= u_ff; pv_ff <= v_ff + 1'b1;
                     state_ff <= (v_ff == (CoordW+1)'(SideLen-1)) ? ST_EMIT : ST_SCAN;
                  end
               end else begin
                  if (i_ff[0] && face_ok && cand_col_ff == col_ff && !covered) begin
                     if (pu_ff + 1'b1 == u_ff + {1'b0, w_ff}) begin
                        h_ff <= h_ff + 1'b1;
                        pu_ff <= u_ff;
                        pv_ff <= pv_ff + 1'b1;
                        state_ff <= (pv_ff == (CoordW+1)'(SideLen-1)) ? ST_EMIT : ST_SCAN;
                     end else begin
                        pu_ff <= pu_ff + 1'b1;
                        state_ff <= ST_SCAN;
                     end
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               // The newest rectangle waits in pend_ff until it is known whether it is last.
               if (cnt_ff == '0 || slot_free) begin
                  for (int j = 0; j < SideLen; j++) begin
                     for (int k = 0; k < SideLen; k++) begin
                        if (j >= v_ff && j < v_ff + h_ff && k >= u_ff && k < u_ff + w_ff)
                           cov_ff[j*SideLen+k] <= 1'b1;
                     end
                  end
                  if (cnt_ff != '0) rsp_ff <= pend_ff;
                  pend_ff <= rsp_word_type'{side: side_ff, slice: slice_ff,
                     u_start: u_ff[CoordW-1:0], v_start: v_ff[CoordW-1:0],
                     width: w_ff, height: h_ff, color: col_ff,
                     none_found: 1'b0, last: 1'b0};
                  cnt_ff <= cnt_ff + 1'b1;
                  phase_ff <= PH_SEED;
                  if (cnt_ff == CountW'(MaxOut-1)
                        || (next_u >= (CoordW+1)'(SideLen)
                            && v_ff == (CoordW+1)'(SideLen-1))) begin
                     state_ff <= ST_FLUSH;
                  end else if (next_u >= (CoordW+1)'(SideLen)) begin
                     state_ff <= ST_SCAN;
                     u_ff <= '0; pu_ff <= '0;
                     v_ff <= v_ff + 1'b1; pv_ff <= v_ff + 1'b1;
                  end else begin
                     state_ff <= ST_SCAN;
                     u_ff <= next_u; pu_ff <= next_u;
                     pv_ff <= v_ff;
                  end
               end
            end
            ST_FLUSH: begin
               if (slot_free) begin
                  rsp_ff <= fin_word;
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMPTY: begin
               if (slot_free) begin
                  rsp_ff <= rsp_word_type'{none_found: 1'b1, last: 1'b1, default: '0};
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: design/vgfm_checker.sv
// Port checker for the voxel mesher, bound to the top level.
`timescale 1ns / 1ps
module vgfm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_none_found,
   input logic rsp_last,
   input logic [3:0] rsp_width
);
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_found |-> rsp_last) else $error("none without last");
   a_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_none_found |-> rsp_width != 4'd0) else $error("zero width");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req taken with rsp pending");
endmodule

bind voxel_greedy_face_mesher_core vgfm_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_none_found(rsp.data.none_found),
   .rsp_last(rsp.data.last), .rsp_width(rsp.data.width)
);
